@@ hw/rtl/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// spm_pkg
// Types, codes and size constants shared by the slotted page manager.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int MAX_SLOTS_DEF    = 1024;
	localparam int ENTRY_BYTES      = 4;

	typedef enum logic [2:0] {
		CMD_INSERT  = 3'd0,
		CMD_UPDATE  = 3'd1,
		CMD_DELETE  = 3'd2,
		CMD_READ    = 3'd3,
		CMD_COMPACT = 3'd4,
		CMD_WBYTE   = 3'd5,
		CMD_RBYTE   = 3'd6,
		CMD_NOP     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NO_SLOT  = 2'd2,
		ST_NO_XFER  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIR_RD,
		S_DIR_OP,
		S_BYTE_RD,
		S_OUT,
		S_CP_COPY,
		S_CP_DIR_RD,
		S_CP_DIR_OP,
		S_CP_MOVE_RD,
		S_CP_MOVE_WR
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [9:0]  slot_index;
		logic [12:0] byte_count;
		logic [7:0]  write_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  assigned_slot;
		logic [12:0] stored_length;
		logic [7:0]  read_value;
		logic [12:0] free_bytes;
		logic [10:0] directory_entries;
	} out_word_t;

endpackage

@@ hw/rtl/spm_ram.sv @@
// ----------------------------------------------------------------------------
// spm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module spm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ hw/rtl/slotted_page_manager.sv @@
// ----------------------------------------------------------------------------
// slotted_page_manager
// Slotted page engine: directory, tuple and scratch stores, command sequencer.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | word
// in      | in  | in_valid/in_stall  | in_word_t: command, slot, count, value
// out     | out | out_valid/out_stall| out_word_t: status, slot, lengths
//
// Directory commands pass S_DIR_RD, S_DIR_OP and S_OUT from accept to the result
// word; write byte passes S_DIR_RD and S_OUT; read byte adds S_BYTE_RD when a read
// transfer is open. The directory and tuple RAMs have a registered read.
// Compact runs a copy sweep of the page into scratch, then a directory read and
// write per entry, and a scratch read and page write per moved byte.
// Reset clears only control state; the RAMs need no clearing pass.
// in_stall is high while a word is in work or a result waits to be taken.
// ----------------------------------------------------------------------------
module slotted_page_manager import spm_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam int AW = $clog2(PAGE_BYTES);
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int PW = AW + 1;
	localparam int CW = SW + 1;
	localparam int XW = PW + 2;

	state_t state_q, state_nx;

	in_word_t    cmd_q;
	mode_t       mode_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] fp_q;
	logic [AW-1:0] cur_q;
	logic [PW-1:0] left_q;
	out_word_t   res_q;
	logic        out_valid_q;
	logic [CW-1:0] idx_q;
	logic [PW-1:0] top_q;
	logic [PW-1:0] k_q;
	logic [PW-1:0] off_q, len_q;
	logic [AW:0]   sweep_q;

	// memory ports
	logic          dir_we, tup_we, scr_we;
	logic [SW-1:0] dir_addr;
	logic [25:0]   dir_wdata, dir_rdata;
	logic [AW-1:0] tup_addr, scr_addr;
	logic [7:0]    tup_wdata, tup_rdata, scr_rdata;

	spm_ram #(.WIDTH(26), .DEPTH(MAX_SLOTS)) u_dir (
		.clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata));
	spm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_tup (
		.clk(clk), .we(tup_we), .addr(tup_addr), .wdata(tup_wdata), .rdata(tup_rdata));
	spm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_scr (
		.clk(clk), .we(scr_we), .addr(scr_addr), .wdata(tup_rdata), .rdata(scr_rdata));

	// directory entry fields, widened to page width
	logic [PW-1:0] d_off, d_len;
	assign d_off = PW'(dir_rdata[25:13]);
	assign d_len = PW'(dir_rdata[12:0]);

	// free space, clamped at zero
	logic signed [XW:0] free_raw;
	logic [PW-1:0]      free_now;
	assign free_raw = $signed({2'b00, fp_q}) - (XW+1)'(HEADER_BYTES)
		- $signed({1'b0, (XW)'({count_q, 2'b00})});
	assign free_now = free_raw[XW] ? '0 : PW'(free_raw);

	logic [PW-1:0] blen;
	assign blen = PW'(cmd_q.byte_count);

	// insert fits: free directory slot and room for tuple plus entry
	logic ins_ok;
	assign ins_ok = (count_q < CW'(MAX_SLOTS))
		&& ((PW+1)'(blen) + (PW+1)'(ENTRY_BYTES) <= (PW+1)'(free_now));

	logic idx_in;
	assign idx_in = (CW'(cmd_q.slot_index) < count_q) && (32'(cmd_q.slot_index) < MAX_SLOTS);

	logic [SW-1:0] cidx;
	assign cidx = SW'(cmd_q.slot_index);

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = res_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					state_nx = S_DIR_RD;
				end
			end
			S_DIR_RD: begin
				case (cmd_t'(cmd_q.command))
					CMD_COMPACT: state_nx = S_CP_COPY;
					CMD_WBYTE:   state_nx = S_OUT;
					CMD_RBYTE:   state_nx = (mode_q == MODE_READ) ? S_BYTE_RD : S_OUT;
					CMD_NOP:     state_nx = S_OUT;
					default:     state_nx = S_DIR_OP;
				endcase
			end
			S_DIR_OP:  state_nx = S_OUT;
			S_BYTE_RD: state_nx = S_OUT;
			S_OUT:     state_nx = S_IDLE;
			S_CP_COPY: begin
				if (sweep_q == (AW+1)'(PAGE_BYTES)) begin
					state_nx = S_CP_DIR_RD;
				end
			end
			S_CP_DIR_RD: begin
				state_nx = (idx_q >= count_q) ? S_OUT : S_CP_DIR_OP;
			end
			S_CP_DIR_OP: begin
				state_nx = S_CP_DIR_RD;
				if (d_off != '0 && d_len <= top_q && d_len != '0) begin
					state_nx = S_CP_MOVE_RD;
				end
			end
			S_CP_MOVE_RD: state_nx = S_CP_MOVE_WR;
			S_CP_MOVE_WR: state_nx = (k_q + 1'b1 == len_q) ? S_CP_DIR_RD : S_CP_MOVE_RD;
			default: state_nx = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		dir_we    = 1'b0;
		dir_addr  = cidx;
		dir_wdata = '0;
		tup_we    = 1'b0;
		tup_addr  = cur_q;
		tup_wdata = cmd_q.write_value;
		scr_we    = 1'b0;
		scr_addr  = AW'(sweep_q);
		case (state_q)
			S_DIR_RD: begin
				if (cmd_t'(cmd_q.command) == CMD_WBYTE && mode_q == MODE_WRITE) begin
					tup_we = 1'b1;
				end
			end
			S_DIR_OP: begin
				case (cmd_t'(cmd_q.command))
					CMD_INSERT: begin
						dir_addr = SW'(count_q);
						if (ins_ok) begin
							dir_we    = 1'b1;
							dir_wdata = {13'(fp_q - blen), 13'(blen)};
						end
					end
					CMD_UPDATE: begin
						if (idx_in && d_off != '0) begin
							if (blen <= d_len) begin
								dir_we = 1'b1;
								dir_wdata = {dir_rdata[25:13], 13'(blen)};
							end else if (blen <= free_now) begin
								dir_we = 1'b1;
								dir_wdata = {13'(fp_q - blen), 13'(blen)};
							end
						end
					end
					CMD_DELETE: begin
						dir_we = idx_in;
					end
					default: ;
				endcase
			end
			S_CP_COPY: begin
				// read page at sweep, write scratch one behind
				tup_addr = AW'(sweep_q);
				scr_addr = AW'(sweep_q - 1'b1);
				scr_we   = (sweep_q != '0);
			end
			S_CP_DIR_RD: dir_addr = SW'(idx_q);
			S_CP_DIR_OP: begin
				dir_addr = SW'(idx_q);
				if (d_off != '0 && d_len <= top_q) begin
					dir_we    = 1'b1;
					dir_wdata = {13'(top_q - d_len), dir_rdata[12:0]};
				end
			end
			S_CP_MOVE_RD: scr_addr = AW'(off_q + k_q);
			S_CP_MOVE_WR: begin
				tup_we    = 1'b1;
				tup_addr  = AW'(top_q + k_q);
				tup_wdata = scr_rdata;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_NONE;
			count_q     <= '0;
			fp_q        <= PW'(PAGE_BYTES);
			cur_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			sweep_q     <= '0;
			idx_q       <= '0;
			k_q         <= '0;
		end else begin
			state_q <= state_nx;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q <= in_word;
						res_q <= '0;
						if (in_word.command <= CMD_COMPACT) begin
							mode_q <= MODE_NONE;
						end
					end
				end
				S_DIR_RD: begin
					case (cmd_t'(cmd_q.command))
						CMD_WBYTE: begin
							if (mode_q == MODE_WRITE && left_q != '0) begin
								cur_q  <= cur_q + 1'b1;
								left_q <= left_q - 1'b1;
								if (left_q == PW'(1)) mode_q <= MODE_NONE;
							end else begin
								res_q.status <= ST_NO_XFER;
							end
						end
						CMD_RBYTE: begin
							if (!(mode_q == MODE_READ && left_q != '0)) begin
								res_q.status <= ST_NO_XFER;
							end
						end
						CMD_COMPACT: begin
							sweep_q <= '0;
							idx_q   <= '0;
							k_q     <= '0;
							top_q   <= PW'(PAGE_BYTES);
						end
						default: ;
					endcase
				end
				S_BYTE_RD: begin
					res_q.read_value <= tup_rdata;
					cur_q  <= cur_q + 1'b1;
					left_q <= left_q - 1'b1;
					if (left_q == PW'(1)) mode_q <= MODE_NONE;
				end
				S_DIR_OP: begin
					case (cmd_t'(cmd_q.command))
						CMD_INSERT: begin
							if (ins_ok) begin
								res_q.assigned_slot <= 10'(count_q);
								count_q <= count_q + 1'b1;
								fp_q    <= fp_q - blen;
								cur_q   <= AW'(fp_q - blen);
								left_q  <= blen;
								mode_q  <= (blen != '0) ? MODE_WRITE : MODE_NONE;
							end else begin
								res_q.status <= ST_NO_SPACE;
							end
						end
						CMD_UPDATE: begin
							if (!(idx_in && d_off != '0)) begin
								res_q.status <= ST_NO_SLOT;
							end else if (blen <= d_len) begin
								cur_q  <= AW'(d_off);
								left_q <= blen;
								mode_q <= (blen != '0) ? MODE_WRITE : MODE_NONE;
							end else if (blen <= free_now) begin
								fp_q   <= fp_q - blen;
								cur_q  <= AW'(fp_q - blen);
								left_q <= blen;
								mode_q <= MODE_WRITE;
							end else begin
								res_q.status <= ST_NO_SPACE;
							end
						end
						CMD_DELETE: begin
							if (!idx_in) res_q.status <= ST_NO_SLOT;
						end
						CMD_READ: begin
							if (!(idx_in && d_off != '0)) begin
								res_q.status <= ST_NO_SLOT;
							end else begin
								res_q.stored_length <= 13'(d_len);
								cur_q  <= AW'(d_off);
								left_q <= d_len;
								mode_q <= (d_len != '0) ? MODE_READ : MODE_NONE;
							end
						end
						default: ;
					endcase
				end
				S_CP_COPY: sweep_q <= sweep_q + 1'b1;
				S_CP_DIR_OP: begin
					idx_q <= idx_q + 1'b1;
					if (d_off != '0 && d_len <= top_q) begin
						top_q <= top_q - d_len;
						off_q <= d_off;
						len_q <= d_len;
					end
				end
				S_CP_MOVE_WR: begin
					if (k_q + 1'b1 == len_q) begin
						k_q <= '0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_OUT: begin
					if (cmd_t'(cmd_q.command) == CMD_COMPACT) begin
						fp_q <= top_q;
					end
					res_q.free_bytes        <= 13'(free_now);
					res_q.directory_entries <= 11'(count_q);
					out_valid_q             <= 1'b1;
				end
				default: ;
			endcase
			// free pointer settles before the result word samples it
			if (state_q == S_CP_DIR_RD && state_nx == S_OUT) begin
				fp_q <= top_q;
			end
		end
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result waits");
	a_out_from_s: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT) else $error("result outside S_OUT");
	a_fp_range: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= PW'(PAGE_BYTES)) else $error("free pointer past page end");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SLOTS)) else $error("directory count overflow");
`endif

endmodule

@@ verif/tb_slotted_page_manager.sv @@
// ----------------------------------------------------------------------------
// tb_slotted_page_manager
// Drives random and directed page commands into the slotted page manager,
// predicts each result word with a behavioral page model and compares the
// results field by field, in order.
// ----------------------------------------------------------------------------
module tb_slotted_page_manager;
	import spm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE  = PAGE_BYTES_DEF;
	localparam int HDR   = HEADER_BYTES_DEF;
	localparam int SLOTS = MAX_SLOTS_DEF;

	// Page model and result queue
	class page_scoreboard;
		logic [7:0]  page_mem [PAGE];
		bit          written [PAGE];
		int unsigned slot_off [SLOTS];
		int unsigned slot_len [SLOTS];
		int unsigned n_entries;
		int unsigned free_ptr;
		int unsigned cursor;
		int unsigned remaining;
		mode_t       xfer;
		out_word_t   pending [$];
		int unsigned mismatches;

		function void clear();
			foreach (written[i]) written[i] = 0;
			n_entries = 0;
			free_ptr  = PAGE;
			cursor    = 0;
			remaining = 0;
			xfer      = MODE_NONE;
			mismatches = 0;
		endfunction

		function int unsigned free_space();
			int f;
			f = int'(free_ptr) - HDR - ENTRY_BYTES * int'(n_entries);
			return (f < 0) ? 0 : unsigned'(f);
		endfunction

		function void open_xfer(mode_t m, int unsigned a, int unsigned n);
			if (n == 0) begin
				xfer = MODE_NONE;
				return;
			end
			xfer      = m;
			cursor    = a;
			remaining = n;
		endfunction

		function void step_cursor();
			cursor++;
			remaining--;
			if (remaining == 0) xfer = MODE_NONE;
		endfunction

		function bit slot_live(int unsigned id);
			return id < n_entries && slot_off[id] != 0;
		endfunction

		function void repack();
			logic [7:0] copy [PAGE];
			bit         cw [PAGE];
			int         top;
			copy = page_mem;
			cw = written;
			top = PAGE;
			for (int i = 0; i < n_entries; i++) begin
				if (slot_off[i] == 0 || top - int'(slot_len[i]) < 0) continue;
				top -= slot_len[i];
				for (int k = 0; k < slot_len[i]; k++) begin
					page_mem[top + k] = copy[slot_off[i] + k];
					written[top + k]  = cw[slot_off[i] + k];
				end
				slot_off[i] = unsigned'(top);
			end
			free_ptr = unsigned'(top);
		endfunction

		// Apply one accepted command word and queue the expected result
		function void note_command(in_word_t w);
			out_word_t r;
			int unsigned id, n, a;
			id = 32'(w.slot_index);
			n  = 32'(w.byte_count);
			r  = '0;
			if (w.command <= CMD_COMPACT) xfer = MODE_NONE;
			case (cmd_t'(w.command))
				CMD_INSERT: begin
					if (n_entries >= SLOTS || n + ENTRY_BYTES > free_space()) begin
						r.status = ST_NO_SPACE;
					end else begin
						a = free_ptr - n;
						slot_off[n_entries] = a;
						slot_len[n_entries] = n;
						r.assigned_slot = 10'(n_entries);
						n_entries++;
						free_ptr = a;
						open_xfer(MODE_WRITE, a, n);
					end
				end
				CMD_UPDATE: begin
					if (!slot_live(id)) begin
						r.status = ST_NO_SLOT;
					end else if (n <= slot_len[id]) begin
						slot_len[id] = n;
						open_xfer(MODE_WRITE, slot_off[id], n);
					end else if (n > free_space()) begin
						r.status = ST_NO_SPACE;
					end else begin
						a = free_ptr - n;
						slot_off[id] = a;
						slot_len[id] = n;
						free_ptr = a;
						open_xfer(MODE_WRITE, a, n);
					end
				end
				CMD_DELETE: begin
					if (id >= n_entries) begin
						r.status = ST_NO_SLOT;
					end else begin
						slot_off[id] = 0;
						slot_len[id] = 0;
					end
				end
				CMD_READ: begin
					if (!slot_live(id)) begin
						r.status = ST_NO_SLOT;
					end else begin
						r.stored_length = 13'(slot_len[id]);
						open_xfer(MODE_READ, slot_off[id], slot_len[id]);
					end
				end
				CMD_COMPACT: repack();
				CMD_WBYTE: begin
					if (xfer != MODE_WRITE || remaining == 0) begin
						r.status = ST_NO_XFER;
					end else begin
						page_mem[cursor] = w.write_value;
						written[cursor]  = 1;
						step_cursor();
					end
				end
				CMD_RBYTE: begin
					if (xfer != MODE_READ || remaining == 0) begin
						r.status = ST_NO_XFER;
					end else begin
						r.read_value = page_mem[cursor];
						step_cursor();
					end
				end
				default: ;
			endcase
			r.free_bytes = 13'(free_space());
			r.directory_entries = 11'(n_entries);
			pending.push_back(r);
		endfunction

		// True when a read byte now would hit a never-written byte
		function bit rbyte_unsafe();
			return xfer == MODE_READ && remaining != 0 && !written[cursor];
		endfunction

		function void check_result(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status || got.assigned_slot !== e.assigned_slot ||
			    got.stored_length !== e.stored_length ||
			    got.read_value !== e.read_value || got.free_bytes !== e.free_bytes ||
			    got.directory_entries !== e.directory_entries) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp st=%0d slot=%0d len=%0d rv=%0d free=%0d n=%0d",
						e.status, e.assigned_slot, e.stored_length, e.read_value,
						e.free_bytes, e.directory_entries);
					$display("          got st=%0d slot=%0d len=%0d rv=%0d free=%0d n=%0d",
						got.status, got.assigned_slot, got.stored_length,
						got.read_value, got.free_bytes, got.directory_entries);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_word;

	page_scoreboard sb;
	int unsigned    sent;
	int unsigned    out_wait;

	slotted_page_manager dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Send one command word, with a random gap before it
	task automatic send_word(cmd_t c, int unsigned id, int unsigned n, int unsigned v);
		in_word_t w;
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if ($urandom_range(0, 1)) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			in_word <= in_word_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		// byte reads into unwritten storage are not allowed
		if (c == CMD_RBYTE && sb.rbyte_unsafe()) c = CMD_NOP;
		w.command = c;
		w.slot_index = 10'(id);
		w.byte_count = 13'(n);
		w.write_value = 8'(v);
		in_word <= w;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_command(w);
		sent++;
	endtask

	task automatic stream_write(int unsigned n);
		for (int k = 0; k < n; k++) send_word(CMD_WBYTE, $urandom, $urandom, $urandom_range(0, 255));
	endtask

	task automatic stream_read(int unsigned n);
		for (int k = 0; k < n; k++) send_word(CMD_RBYTE, $urandom, $urandom, $urandom);
	endtask

	function automatic int unsigned pick_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 10) return 0;
		if (p < 85) return $urandom_range(1, 12);
		if (p < 97) return $urandom_range(13, 60);
		return $urandom_range(0, 8191);
	endfunction

	function automatic int unsigned pick_slot();
		if (sb.n_entries == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
		return $urandom_range(0, sb.n_entries - 1);
	endfunction

	// Bytes to write after an insert or update: the open length, long ones and some others cut
	function automatic int unsigned write_burst();
		int unsigned m;
		if (sb.xfer != MODE_WRITE) return $urandom_range(0, 2);
		m = sb.remaining;
		if (m > 64 || $urandom_range(0, 9) == 0) m = $urandom_range(0, m > 64 ? 64 : m);
		return m;
	endfunction

	// Result side: per-word stall count, then check
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (!out_stall) begin
				sb.check_result(out_word);
				out_wait = $urandom_range(0, 19);
			end else if (out_wait != 0) begin
				out_wait--;
			end
		end
		out_stall <= (out_wait != 0);
	end

	initial begin
		int unsigned n;
		sb = new();
		sb.clear();
		sent = 0;
		out_wait = 0;
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		in_word = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty page errors, extremes, every command
		send_word(CMD_WBYTE, 0, 0, 8'hff);
		send_word(CMD_RBYTE, 0, 0, 0);
		send_word(CMD_READ, 0, 0, 0);
		send_word(CMD_UPDATE, 1023, 5, 0);
		send_word(CMD_DELETE, 1023, 0, 0);
		send_word(CMD_INSERT, 0, 8191, 0);
		send_word(CMD_INSERT, 0, 4096, 0);
		send_word(CMD_INSERT, 0, 0, 0);
		send_word(CMD_WBYTE, 0, 0, 8'h00);
		send_word(CMD_INSERT, 1023, 3, 0);
		stream_write(3);
		send_word(CMD_UPDATE, 1, 2, 0);
		send_word(CMD_WBYTE, 0, 0, 8'haa);
		send_word(CMD_COMPACT, 0, 0, 0);
		send_word(CMD_READ, 1, 0, 0);
		stream_read(2);
		send_word(CMD_RBYTE, 0, 0, 0);
		send_word(CMD_DELETE, 0, 0, 0);
		send_word(CMD_DELETE, 0, 0, 0);
		send_word(CMD_READ, 0, 0, 0);
		send_word(CMD_NOP, 1023, 8191, 255);
		send_word(CMD_INSERT, 0, 4070, 0);

		// Random: mostly well-formed command sequences with payload streams
		while (sent < 1650) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: begin
					send_word(CMD_INSERT, $urandom, pick_len(), 0);
					stream_write(write_burst());
				end
				6, 7, 8: begin
					send_word(CMD_UPDATE, pick_slot(), pick_len(), 0);
					stream_write(write_burst());
				end
				9, 10, 11, 12: begin
					send_word(CMD_READ, pick_slot(), $urandom, 0);
					n = (sb.xfer == MODE_READ) ? sb.remaining : 0;
					stream_read($urandom_range(0, 7) == 0 ? n + 1 : n);
				end
				13, 14: begin
					send_word(CMD_DELETE, pick_slot(), $urandom, 0);
				end
				15: begin
					send_word(CMD_COMPACT, $urandom, $urandom, $urandom);
				end
				16: begin
					send_word(cmd_t'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
				end
				default: begin
					// fill the page, sometimes the directory too
					n = $urandom_range(0, 3);
					send_word(CMD_INSERT, 0, n, 0);
					stream_write((sb.xfer == MODE_WRITE) ? sb.remaining : 0);
				end
			endcase
		end
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#40ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
